FILE: hw/rtl/appliance_link_supervisor_core_macros.svh
// Assertion macros shared by the supervisor RTL.
`ifndef APPLIANCE_LINK_SUPERVISOR_CORE_MACROS_SVH
`define APPLIANCE_LINK_SUPERVISOR_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ALS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ALS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/als_pkg.sv
// ----------------------------------------------------------------------------
// als_pkg
// Types and constants shared by the appliance link supervisor.
// ----------------------------------------------------------------------------
package als_pkg;

  localparam int unsigned DefTimeBits = 32;
  localparam int unsigned MaxRes      = 8;
  localparam int unsigned CntBits     = 3;

  typedef enum logic [2:0] {
    MODE_UPDATE  = 3'd0,
    MODE_CLEAN   = 3'd1,
    MODE_CSTOP   = 3'd2,
    MODE_BSTOP   = 3'd3,
    MODE_STANDBY = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_POLL   = 2'd1,
    KIND_READ   = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_DISCONNECT = 3'd1,
    REG_CLEAN_WIN  = 3'd2,
    REG_PULSES     = 3'd3,
    REG_STEAM_MASK = 3'd4,
    REG_HEAT_MASK  = 3'd5,
    REG_PUMP_MASK  = 3'd6,
    REG_REASSERT   = 3'd7
  } reg_e;

  localparam logic [15:0] AddrMode      = 16'h0000;
  localparam logic [15:0] AddrSync0     = 16'h0400;
  localparam logic [15:0] AddrSync1     = 16'h0401;
  localparam logic [15:0] AddrSync2     = 16'h0402;
  localparam logic [15:0] AddrSync3     = 16'h0406;
  localparam logic [15:0] AddrSteam     = 16'h00E1;
  localparam logic [15:0] ValClean      = 16'h0082;
  localparam logic [15:0] ValSteamOn    = 16'h0081;
  localparam logic [15:0] WakeDelayMs   = 16'd500;
  localparam logic [15:0] RereadMs      = 16'd60000;
  localparam logic [15:0] QuietPollMs   = 16'd10000;
  localparam logic [15:0] ReadLen       = 16'h0020;
  localparam logic [15:0] PulseGapMs    = 16'd1000;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [15:0] value;
    logic        last;
    logic        brew_flag;
    logic        link_up;
    logic        steam_flag;
    logic        heater_on;
    logic        pump_on;
    logic        clean_active;
    logic        clean_ready;
    logic [1:0]  shot_edge;
  } res_t;

  // Work list for one event, produced by the front part.
  typedef struct packed {
    res_t [MaxRes-1:0] items;
    logic [CntBits-1:0] last_idx;
  } batch_t;

  localparam res_t ResZero = '0;

  function automatic res_t mk_cmd(logic [1:0] kind, logic [15:0] addr, logic [15:0] value);
    res_t r;
    r = ResZero;
    r.kind  = kind;
    r.addr  = addr;
    r.value = value;
    return r;
  endfunction

endpackage

FILE: hw/rtl/als_if.sv
// ----------------------------------------------------------------------------
// als_stream_if
// Valid/ready channel carrying a payload of parameterised type.
// ----------------------------------------------------------------------------
interface als_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/als_in_t_pkg.sv
// ----------------------------------------------------------------------------
// als_io_pkg
// Payload types of the supervisor's channels.
// ----------------------------------------------------------------------------
package als_io_pkg;
  import als_pkg::*;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] now_ms;
    logic        r_frame;
    logic        r_brew;
    logic [7:0]  r_flags;
    logic        z_frame;
    logic        z_shot;
    logic        standby_on;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [19:0] data;
  } cfg_item_t;
endpackage

FILE: hw/rtl/als_front.sv
// ----------------------------------------------------------------------------
// als_front
// Applies one event to the supervisor state and builds its result list.
// ----------------------------------------------------------------------------
module als_front
  import als_pkg::*;
  import als_io_pkg::*;
#(
  parameter int unsigned TimeBits = DefTimeBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  als_stream_if.sink   in_s,
  als_stream_if.sink   cfg_s,
  output batch_t    batch_o,
  output logic      batch_valid_o,
  input  logic      batch_ready_i
);
  localparam int unsigned TB = TimeBits;
  typedef logic [TB-1:0] tm_t;

  // Configuration.
  logic [15:0] debounce_q, disconnect_q;
  logic [19:0] clean_win_q;
  logic [3:0]  pulse_cnt_q;
  logic [7:0]  steam_m_q, heat_m_q, pump_m_q;
  logic        reassert_q;

  // State.
  tm_t  wake_due_q, idle_since_q, last_frame_q, clean_until_q;
  tm_t  next_pulse_q, shot_start_q, reread_q;
  logic [3:0] pulses_q;
  logic [7:0] flags_q;
  logic second_q, brew_q, prev_brew_q, conn_q, shot_q;

  tm_t  wake_due_d, idle_since_d, last_frame_d, clean_until_d;
  tm_t  next_pulse_d, shot_start_d, reread_d;
  logic [3:0] pulses_d;
  logic [7:0] flags_d;
  logic second_d, brew_d, prev_brew_d, conn_d, shot_d;

  in_item_t in_p;
  batch_t   b;
  logic [CntBits:0] n;
  logic [1:0] edge_sel;
  tm_t now, half;
  logic take;

  assign cfg_s.ready = 1'b1;
  assign in_s.ready  = batch_ready_i;
  assign take        = in_s.valid & in_s.ready;
  assign in_p        = in_s.payload;
  assign now         = TB'(in_p.now_ms);
  assign half        = tm_t'(1) << (TB - 1);

  function automatic logic reached(tm_t t, tm_t due, tm_t h);
    tm_t diff;
    diff = t - due;
    return diff < h;
  endfunction

  function automatic tm_t dline(tm_t t, tm_t delta);
    tm_t d;
    d = t + delta;
    return (d == '0) ? tm_t'(1) : d;
  endfunction

  always_comb begin
    res_t st;
    logic sb;
    wake_due_d = wake_due_q; idle_since_d = idle_since_q; last_frame_d = last_frame_q;
    clean_until_d = clean_until_q; next_pulse_d = next_pulse_q;
    shot_start_d = shot_start_q; reread_d = reread_q; pulses_d = pulses_q;
    flags_d = flags_q; second_d = second_q; brew_d = brew_q;
    prev_brew_d = prev_brew_q; conn_d = conn_q; shot_d = shot_q;
    b = '0;
    n = '0;
    edge_sel = 2'd0;
    sb = in_p.standby_on;

    // The list never exceeds seven commands, so no overflow guard is needed.
    unique case (in_p.mode)
      MODE_UPDATE: begin
        if (wake_due_q != '0 && reached(now, wake_due_q, half)) begin
          wake_due_d = '0;
          b.items[0] = mk_cmd(KIND_WRITE, AddrMode, 16'h0001);
          b.items[1] = mk_cmd(KIND_WRITE, AddrSync0, 16'h0000);
          b.items[2] = mk_cmd(KIND_WRITE, AddrSync1, 16'h0000);
          b.items[3] = mk_cmd(KIND_WRITE, AddrSync2, 16'h0000);
          b.items[4] = mk_cmd(KIND_WRITE, AddrSync3, 16'h0000);
          n = 4'd5;
        end
        if (in_p.r_frame) begin
          flags_d = in_p.r_flags;
          last_frame_d = now;
          conn_d = 1'b1;
          if (in_p.r_brew) begin
            brew_d = 1'b1;
            idle_since_d = '0;
          end else if (brew_q) begin
            if (idle_since_q == '0) idle_since_d = now;
            if ((now - idle_since_d) > TB'(debounce_q)) begin
              brew_d = 1'b0;
              idle_since_d = '0;
              if (second_q) begin
                second_d = 1'b0;
                wake_due_d = dline(now, TB'(WakeDelayMs));
              end
            end
          end
        end
        if (in_p.z_frame) begin
          shot_d = in_p.z_shot;
          last_frame_d = now;
          conn_d = 1'b1;
          if (in_p.z_shot) begin
            brew_d = 1'b1;
            idle_since_d = '0;
          end
        end
        if (clean_until_q != '0) begin
          if (reached(now, clean_until_q, half)) begin
            clean_until_d = '0;
            pulses_d = '0;
            b.items[n[CntBits-1:0]] = mk_cmd(KIND_POLL, 16'h0000, 16'h0000);
            n = n + 1'b1;
          end else if (pulses_q != '0) begin
            if (brew_d) begin
              pulses_d = '0;
              b.items[n[CntBits-1:0]] = mk_cmd(KIND_POLL, 16'h0000, QuietPollMs);
              n = n + 1'b1;
            end else if (reached(now, next_pulse_q, half)) begin
              next_pulse_d = now + TB'(PulseGapMs);
              pulses_d = pulses_q - 1'b1;
              b.items[n[CntBits-1:0]] = mk_cmd(KIND_WRITE, AddrSteam, ValClean);
              n = n + 1'b1;
              if (pulses_d == '0) begin
                b.items[n[CntBits-1:0]] = mk_cmd(KIND_POLL, 16'h0000, QuietPollMs);
                n = n + 1'b1;
              end
            end
          end
        end
        if (!prev_brew_q && brew_d) begin
          shot_start_d = now;
          edge_sel = 2'd1;
        end
        if (prev_brew_q && !brew_d) edge_sel = 2'd2;
        prev_brew_d = brew_d;
        if (conn_d && !brew_d && !shot_d && clean_until_d == '0 &&
            (now - reread_q) >= TB'(RereadMs)) begin
          reread_d = now;
          b.items[n[CntBits-1:0]] = mk_cmd(KIND_READ, AddrMode, ReadLen);
          n = n + 1'b1;
        end
        if (conn_d && (now - last_frame_d) > TB'(disconnect_q)) conn_d = 1'b0;
      end
      MODE_CLEAN: begin
        clean_until_d = dline(now, TB'(clean_win_q));
        pulses_d = pulse_cnt_q;
        next_pulse_d = now;
      end
      MODE_CSTOP: begin
        clean_until_d = '0;
        pulses_d = '0;
        b.items[0] = mk_cmd(KIND_POLL, 16'h0000, 16'h0000);
        n = 4'd1;
      end
      MODE_BSTOP, MODE_STANDBY: begin
        if (in_p.mode == MODE_BSTOP) sb = 1'b1;
        b.items[0] = mk_cmd(KIND_WRITE, AddrMode, {15'd0, ~sb});
        b.items[1] = mk_cmd(KIND_WRITE, AddrSync0, 16'h0000);
        b.items[2] = mk_cmd(KIND_WRITE, AddrSync1, 16'h0000);
        b.items[3] = mk_cmd(KIND_WRITE, AddrSync2, 16'h0000);
        b.items[4] = mk_cmd(KIND_WRITE, AddrSync3, 16'h0000);
        n = 4'd5;
        if (in_p.mode == MODE_BSTOP) begin
          wake_due_d = dline(now, TB'(WakeDelayMs));
          second_d = 1'b1;
        end else if (!sb && reassert_q) begin
          b.items[5] = mk_cmd(KIND_WRITE, AddrSteam, ValSteamOn);
          n = 4'd6;
        end
      end
      default: ;
    endcase

    st = ResZero;
    st.kind = KIND_STATUS;
    st.last = 1'b1;
    st.brew_flag = brew_d;
    st.link_up = conn_d;
    st.steam_flag = |(flags_d & steam_m_q);
    st.heater_on = |(flags_d & heat_m_q);
    st.pump_on = |(flags_d & pump_m_q);
    st.clean_active = clean_until_d != '0;
    st.clean_ready = (clean_until_d != '0) && (pulses_d == '0);
    st.shot_edge = edge_sel;
    b.items[n[CntBits-1:0]] = st;
    b.last_idx = n[CntBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= 16'd1000; disconnect_q <= 16'd3000; clean_win_q <= 20'd135000;
      pulse_cnt_q <= 4'd6; steam_m_q <= 8'd1; heat_m_q <= 8'd2; pump_m_q <= 8'd4;
      reassert_q <= 1'b0;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.payload.index)
        REG_DEBOUNCE:   debounce_q   <= cfg_s.payload.data[15:0];
        REG_DISCONNECT: disconnect_q <= cfg_s.payload.data[15:0];
        REG_CLEAN_WIN:  clean_win_q  <= cfg_s.payload.data;
        REG_PULSES:     pulse_cnt_q  <= cfg_s.payload.data[3:0];
        REG_STEAM_MASK: steam_m_q    <= cfg_s.payload.data[7:0];
        REG_HEAT_MASK:  heat_m_q     <= cfg_s.payload.data[7:0];
        REG_PUMP_MASK:  pump_m_q     <= cfg_s.payload.data[7:0];
        REG_REASSERT:   reassert_q   <= cfg_s.payload.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wake_due_q <= '0; idle_since_q <= '0; last_frame_q <= '0; clean_until_q <= '0;
      next_pulse_q <= '0; shot_start_q <= '0; reread_q <= '0; pulses_q <= '0;
      flags_q <= '0; second_q <= 1'b0; brew_q <= 1'b0; prev_brew_q <= 1'b0;
      conn_q <= 1'b0; shot_q <= 1'b0;
    end else if (take) begin
      wake_due_q <= wake_due_d; idle_since_q <= idle_since_d; last_frame_q <= last_frame_d;
      clean_until_q <= clean_until_d; next_pulse_q <= next_pulse_d;
      shot_start_q <= shot_start_d; reread_q <= reread_d; pulses_q <= pulses_d;
      flags_q <= flags_d; second_q <= second_d; brew_q <= brew_d;
      prev_brew_q <= prev_brew_d; conn_q <= conn_d; shot_q <= shot_d;
    end
  end

  assign batch_o       = b;
  assign batch_valid_o = in_s.valid;
endmodule

FILE: hw/rtl/als_queue.sv
// ----------------------------------------------------------------------------
// als_queue
// Two-entry queue of result lists between the front and back parts.
// ----------------------------------------------------------------------------
`include "appliance_link_supervisor_core_macros.svh"
module als_queue
  import als_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  batch_t wr_data_i,
  input  logic   wr_valid_i,
  output logic   wr_ready_o,
  output batch_t rd_data_o,
  output logic   rd_valid_o,
  input  logic   rd_pop_i
);
  batch_t mem_q [2];
  logic   wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i & wr_ready_o;
  assign pop  = rd_pop_i & rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  `ALS_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q != 2'd3, "queue count out of range")
  `ALS_ASSERT_NEXT(a_full_hold, cnt_q == 2'd2 && !pop, cnt_q == 2'd2, "full queue drained")
  `ALS_ASSERT_IMP(a_ptr_sync, cnt_q == 2'd0 || cnt_q == 2'd2,
                  (cnt_q == 2'd0) == (wp_q == rp_q) || cnt_q == 2'd2, "pointer mismatch")
endmodule

FILE: hw/rtl/als_back.sv
// ----------------------------------------------------------------------------
// als_back
// Issues the items of each queued result list one per cycle while out_s is ready.
// ----------------------------------------------------------------------------
`include "appliance_link_supervisor_core_macros.svh"
module als_back
  import als_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  batch_t batch_i,
  input  logic   batch_valid_i,
  output logic   batch_pop_o,
  als_stream_if.source out_s
);
  logic [CntBits-1:0] idx_q;
  logic fire, at_last;

  assign out_s.valid   = batch_valid_i;
  assign out_s.payload = batch_i.items[idx_q];
  assign fire          = out_s.valid & out_s.ready;
  assign at_last       = idx_q == batch_i.last_idx;
  assign batch_pop_o   = fire & at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else if (fire) idx_q <= at_last ? '0 : idx_q + 1'b1;
  end

  `ALS_ASSERT_IMP(a_last_flag, out_s.valid, out_s.payload.last == at_last,
                  "last flag does not match list end")
  `ALS_ASSERT_IMP(a_idx_bound, batch_valid_i, idx_q <= batch_i.last_idx,
                  "index past list end")
  `ALS_ASSERT_NEXT(a_idx_wrap, batch_pop_o, idx_q == '0, "index not rewound")
endmodule

FILE: hw/rtl/appliance_link_supervisor_core.sv
// ----------------------------------------------------------------------------
// appliance_link_supervisor_core
// Supervisor for a serially linked appliance: event handling and command issue.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  in_s      sink       one event transaction (mode, time, frames)
//  cfg_s     sink       one register write transaction (index, data)
//  out_s     source     commands, then one status transaction marked last
//
// An event is taken when the queue has room; the front updates all
// state in that cycle. The back issues one transaction per cycle while out_s is
// ready, and each result list holds one to eight transactions.
// A two-entry queue lets the next event enter while results still drain.
// Reset clears all state and loads the register defaults; no clearing pass.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module appliance_link_supervisor_core
  import als_pkg::*;
  import als_io_pkg::*;
#(
  parameter int unsigned TimeBits = DefTimeBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  als_stream_if.sink   in_s,
  als_stream_if.sink   cfg_s,
  als_stream_if.source out_s
);
  batch_t front_batch, back_batch;
  logic   front_valid, q_ready, back_valid, back_pop;

  // The front applies an event exactly when the queue can hold its list.
  als_front #(.TimeBits(TimeBits)) u_front (
    .clk_i, .rst_ni, .in_s, .cfg_s,
    .batch_o(front_batch), .batch_valid_o(front_valid), .batch_ready_i(q_ready)
  );

  als_queue u_queue (
    .clk_i, .rst_ni,
    .wr_data_i(front_batch), .wr_valid_i(front_valid), .wr_ready_o(q_ready),
    .rd_data_o(back_batch), .rd_valid_o(back_valid), .rd_pop_i(back_pop)
  );

  als_back u_back (
    .clk_i, .rst_ni,
    .batch_i(back_batch), .batch_valid_i(back_valid), .batch_pop_o(back_pop), .out_s
  );
endmodule
